// ===== rtl/gcrm_pkg.sv =====
// Shared constants for the gray-convert row-mirror block.
`timescale 1ns / 1ps
`default_nettype none

package gcrm_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W     = COL_W + 1;
    localparam int ADDR_W    = COL_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // Configuration register
    localparam int         ROW_WIDTH_W     = 11;
    localparam logic [10:0] ROW_WIDTH_RESET = 11'd1024;

    // Pixel and gray widths
    localparam int PIX_W  = 8;
    localparam int GRAY_W = 8;

    // Luma weights scaled by 1000
    localparam int SUM_W    = 18;
    localparam int WEIGHT_R = 299;
    localparam int WEIGHT_G = 587;
    localparam int WEIGHT_B = 114;

    // sum / 1000 = (sum >> 3) / 125, and x / 125 = (x * DIV_MUL) >> DIV_SH
    // exactly for every x up to 31875
    localparam int DIV_IN_W = SUM_W - 3;
    localparam int DIV_MUL  = 33555;
    localparam int DIV_SH   = 22;
    localparam int PROD_W   = 31;

    // Request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/gcrm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module gcrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gcrm_gray.sv =====
// RGB to gray conversion: floor((299*R + 587*G + 114*B) / 1000).
`timescale 1ns / 1ps
`default_nettype none

module gcrm_gray (
    input  wire logic [gcrm_pkg::PIX_W-1:0]  red,
    input  wire logic [gcrm_pkg::PIX_W-1:0]  green,
    input  wire logic [gcrm_pkg::PIX_W-1:0]  blue,
    output logic      [gcrm_pkg::GRAY_W-1:0] gray
);

    import gcrm_pkg::*;

    logic [SUM_W-1:0]    sum;
    logic [DIV_IN_W-1:0] sum_div8;
    logic [PROD_W-1:0]   prod;

    assign sum = SUM_W'(red)   * SUM_W'(WEIGHT_R)
               + SUM_W'(green) * SUM_W'(WEIGHT_G)
               + SUM_W'(blue)  * SUM_W'(WEIGHT_B);

    // drop the factor of 8 first, then divide by 125 through the reciprocal
    assign sum_div8 = sum[SUM_W-1:3];
    assign prod     = PROD_W'(sum_div8) * PROD_W'(DIV_MUL);
    assign gray     = prod[DIV_SH+GRAY_W-1:DIV_SH];

endmodule

`default_nettype wire

// ===== rtl/gray_convert_row_mirror_unit.sv =====
// Top level: gray conversion with mirrored row output through a ping-pong line store.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall): one transaction per pixel (req_type 0,
//   red/green/blue) or per flush tick (req_type 1). A transaction completes on a
//   rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): gray plus last_of_row, one
//   transaction per mirrored-row pixel, last column first.
//   Config channel (cfg_valid / cfg_ready): writes row_width; cfg_ready is
//   always high. Write it only while the block is idle.
// Rate and pipeline
//   One input transaction per cycle, sustained, while out_stall is low. A result
//   reaches out_valid through the input register (gray math, address select)
//   and then the line-store read register, which doubles as the output
//   register.
// Reset
//   rst_n clears the control state and sets row_width to 1024. The line store
//   is not cleared; only columns written in a completed row are ever read.
// Stall
//   While out_stall holds a valid result, the read register holds. The input
//   register can still take one transaction; after that in_stall rises.

module gray_convert_row_mirror_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gcrm_pkg::ROW_WIDTH_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [gcrm_pkg::PIX_W-1:0]     red,
    input  wire logic [gcrm_pkg::PIX_W-1:0]     green,
    input  wire logic [gcrm_pkg::PIX_W-1:0]     blue,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [gcrm_pkg::GRAY_W-1:0]    gray,
    output logic                                last_of_row
);

    import gcrm_pkg::*;

    // Input-register stage contents
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd;
        logic [ADDR_W-1:0] rd_addr;
        logic              last;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
    } stage_t;

    // Config register
    logic [ROW_WIDTH_W-1:0] row_width_reg;

    // Row bookkeeping
    logic [COL_W-1:0] wr_col_reg, wr_col_next;
    logic             wr_bank_reg, wr_bank_next;
    logic [CNT_W-1:0] pending_reg, pending_next;

    // Pipeline
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic   out_valid_reg;
    logic   out_last_reg;

    logic             in_accept;
    logic             advance;
    logic [CNT_W-1:0] eff_width;
    logic [COL_W-1:0] rd_col;
    logic [CNT_W-1:0] col_plus1;
    logic             is_pixel;

    logic [GRAY_W-1:0] gray_value;
    logic              ram_we;
    logic              ram_re;

    assign cfg_ready = 1'b1;

    // The output register moves when empty or taken; the input register
    // drains into it on the same edge.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign is_pixel  = (req_type == REQ_PIXEL);

    // Clamp the programmed width to the legal range
    always_comb
    begin
        if (32'(row_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = CNT_W'(MAX_WIDTH);
        end
        else if (row_width_reg == '0)
        begin
            eff_width = CNT_W'(1);
        end
        else
        begin
            eff_width = CNT_W'(row_width_reg);
        end
    end

    assign rd_col    = COL_W'(pending_reg - CNT_W'(1));
    assign col_plus1 = CNT_W'(wr_col_reg) + CNT_W'(1);

    // Per-transaction bookkeeping: read the pending row first, then store the pixel
    always_comb
    begin
        wr_col_next  = wr_col_reg;
        wr_bank_next = wr_bank_reg;
        pending_next = pending_reg;

        s1_next.rd      = (pending_reg != '0);
        s1_next.rd_addr = {~wr_bank_reg, rd_col};
        s1_next.last    = (pending_reg == CNT_W'(1));
        s1_next.wr      = is_pixel;
        s1_next.wr_addr = {wr_bank_reg, wr_col_reg};
        s1_next.red     = red;
        s1_next.green   = green;
        s1_next.blue    = blue;

        if (in_accept)
        begin
            if (pending_reg != '0)
            begin
                pending_next = pending_reg - CNT_W'(1);
            end
            if (is_pixel)
            begin
                if (col_plus1 >= eff_width)
                begin
                    // row done: swap banks, the new row replaces any leftovers
                    pending_next = col_plus1;
                    wr_bank_next = ~wr_bank_reg;
                    wr_col_next  = '0;
                end
                else
                begin
                    wr_col_next = COL_W'(col_plus1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            wr_col_reg    <= '0;
            wr_bank_reg   <= 1'b0;
            pending_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                row_width_reg <= cfg_data;
            end
            wr_col_reg  <= wr_col_next;
            wr_bank_reg <= wr_bank_next;
            pending_reg <= pending_next;

            // input register: load on accept, drop when drained
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            // output register: advance or hold under stall
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && s1_reg.rd;
                out_last_reg  <= s1_reg.last;
            end
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
    end

    gcrm_gray u_gray (
        .red   (s1_reg.red),
        .green (s1_reg.green),
        .blue  (s1_reg.blue),
        .gray  (gray_value)
    );

    // Write and read leave the input register together, in transaction order,
    // so a row is always stored before its first mirrored read.
    assign ram_we = s1_valid_reg && s1_reg.wr && advance;
    assign ram_re = s1_valid_reg && s1_reg.rd && advance;

    gcrm_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.wr_addr),
        .wr_data (gray_value),
        .rd_en   (ram_re),
        .rd_addr (s1_reg.rd_addr),
        .rd_data (gray)
    );

    assign out_valid   = out_valid_reg;
    assign last_of_row = out_last_reg;

    // Checks

    // write and read of one transaction always hit opposite banks
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (s1_reg.wr_addr[ADDR_W-1] != s1_reg.rd_addr[ADDR_W-1]))
        else $error("line store write and read in the same bank");

    // never more pending outputs than one row holds
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(MAX_WIDTH))
        else $error("pending count beyond row capacity");

    // a transaction accepted with output pending carries a read into the input register
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pending_reg != '0)) |=> (s1_valid_reg && s1_reg.rd))
        else $error("pending output not scheduled for read");

    // a flush that takes the final output of a row leaves nothing older pending
    a_last_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (pending_reg == CNT_W'(1)) && !is_pixel) |=> (pending_reg == '0))
        else $error("pending count not cleared after last output");

endmodule

`default_nettype wire
